>>> rtl/core/ssr_pkg.sv
`default_nettype none
package ssr_pkg;

	// input item layout on s_axis_tdata
	localparam int CX_W        = 12;
	localparam int CY_W        = 12;
	localparam int SW_W        = 8;
	localparam int HEIGHT_W    = 7;
	localparam int CX_LSB      = 0;
	localparam int CY_LSB      = CX_LSB + CX_W;
	localparam int SW_LSB      = CY_LSB + CY_W;
	localparam int SH_LSB      = SW_LSB + SW_W;
	localparam int IN_BITS     = SH_LSB + HEIGHT_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

	// result item layout on m_axis_tdata
	localparam int XY_W        = 13;
	localparam int SPAN_W_W    = 9;
	localparam int SX_LSB      = 0;
	localparam int SY_LSB      = SX_LSB + XY_W;
	localparam int SPW_LSB     = SY_LSB + XY_W;
	localparam int OUT_BITS    = SPW_LSB + SPAN_W_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// signed working width of the capped span width 2*hw - 2*r + 2*dx + 1
	localparam int LW_CALC_W   = 12;

	// tallest shape still drawn as a plain rectangle
	localparam logic [HEIGHT_W-1:0] PLAIN_LIMIT = HEIGHT_W'(3);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SQRT,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

>>> rtl/core/stadium_span_rasterizer.sv
`default_nettype none
// Stadium span rasterizer. One transfer on s_axis describes a shape (center, width,
// height); the block answers with one transfer on m_axis per row, top row first, and
// raises tlast on the final row. Heights of 3 or less give plain rectangles; taller
// shapes get round caps of radius h/2, where each row's widening comes from an integer
// square root that resolves one bit of the root per cycle. Every row runs
// $clog2(MAX_HEIGHT/2+1) root steps (six at the default) and then offers its span,
// which waits for as long as m_axis stalls; heights above MAX_HEIGHT are drawn as
// MAX_HEIGHT and a height of 0 gives no rows. The square-root unit is the one shared
// resource and paces every row. A new shape is taken only once the last span of the
// previous one has been transferred.
module stadium_span_rasterizer
	import ssr_pkg::*;
#(
	parameter int MAX_HEIGHT = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// center_x[11:0], center_y[23:12], shape_width[31:24], shape_height[38:32], zero fill
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// span_x[12:0], span_y[25:13], span_width[34:26], zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast
);

	// cap radius never exceeds MAX_HEIGHT/2, so r*r - dy*dy fits in SQ_W bits
	localparam int R_W   = $clog2(MAX_HEIGHT / 2 + 1);
	localparam int SQ_W  = 2 * R_W;
	localparam int CNT_W = $clog2(R_W + 1);
	localparam logic [SQ_W-1:0]     BIT_TOP = SQ_W'(1) << (SQ_W - 2);
	localparam logic [HEIGHT_W-1:0] H_MAX   = HEIGHT_W'(MAX_HEIGHT);
	localparam logic [CNT_W-1:0]    LAST_IT = CNT_W'(R_W - 1);

	state_t state_q, state_d;

	// shape registers
	logic [XY_W-1:0]     base_x_q;   // center_x - w/2
	logic [XY_W-1:0]     y_q;        // current row coordinate
	logic [SW_W-1:0]     w_q;
	logic [SW_W-2:0]     hw_q;
	logic [R_W-1:0]      r_q;
	logic                cap_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [HEIGHT_W-1:0] last_row_q;
	logic signed [R_W:0] dy_q;       // row offset from center, -r upward
	logic [SQ_W-1:0]     val_q;      // r*r - dy*dy, kept by running differences

	// square-root working registers
	logic [SQ_W-1:0]     rem_q;
	logic [SQ_W-1:0]     res_q;
	logic [SQ_W-1:0]     bit_q;
	logic [CNT_W-1:0]    cnt_q;

	// output register
	logic [XY_W-1:0]     ox_q;
	logic [XY_W-1:0]     oy_q;
	logic [SPAN_W_W-1:0] ow_q;
	logic                olast_q;

	logic in_fire, out_fire, sqrt_last;

	// unpack the request
	logic [CX_W-1:0]     in_cx;
	logic [CY_W-1:0]     in_cy;
	logic [SW_W-1:0]     in_w;
	logic [HEIGHT_W-1:0] in_h, h_sat;
	logic [R_W-1:0]      in_r;

	assign in_cx = s_axis_tdata[CX_LSB +: CX_W];
	assign in_cy = s_axis_tdata[CY_LSB +: CY_W];
	assign in_w  = s_axis_tdata[SW_LSB +: SW_W];
	assign in_h  = s_axis_tdata[SH_LSB +: HEIGHT_W];
	assign h_sat = (in_h > H_MAX) ? H_MAX : in_h;
	assign in_r  = R_W'(h_sat >> 1);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid & s_axis_tready;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign out_fire      = m_axis_tvalid & m_axis_tready;
	assign sqrt_last     = (cnt_q == LAST_IT);

	// one bit of the root per cycle, from one bit pair of the radicand
	logic [SQ_W:0]   sq_sum;
	logic            sq_ge;
	logic [SQ_W-1:0] rem_nx, res_nx;

	assign sq_sum = {1'b0, res_q} + {1'b0, bit_q};
	assign sq_ge  = ({1'b0, rem_q} >= sq_sum);
	assign rem_nx = sq_ge ? (rem_q - sq_sum[SQ_W-1:0]) : rem_q;
	assign res_nx = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	// span of this row from the finished root
	logic [R_W-1:0]       dx;
	logic [XY_W-1:0]      cap_x;
	logic [LW_CALC_W-1:0] cap_lw;
	logic [SPAN_W_W-1:0]  row_w;
	logic [XY_W-1:0]      row_x;

	assign dx     = res_nx[R_W-1:0];
	assign cap_x  = base_x_q + XY_W'(r_q) - XY_W'(dx);
	assign cap_lw = LW_CALC_W'({hw_q, 1'b0}) - LW_CALC_W'({r_q, 1'b0})
	                + LW_CALC_W'({dx, 1'b0}) + LW_CALC_W'(1);
	assign row_x  = cap_q ? cap_x : base_x_q;
	assign row_w  = !cap_q ? SPAN_W_W'(w_q) :
	                (cap_lw[LW_CALC_W-1] ? '0 : cap_lw[SPAN_W_W-1:0]);

	// next row's r*r - dy*dy: subtract 2*dy + 1
	logic [SQ_W:0]   val_diff;
	logic [SQ_W-1:0] val_nx;

	assign val_diff = {1'b0, val_q} - {{(SQ_W - R_W - 1){dy_q[R_W]}}, dy_q, 1'b1};
	assign val_nx   = val_diff[SQ_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				// drop a zero-height shape at once
				if (in_fire && (h_sat != '0)) state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (sqrt_last) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_fire) state_d = olast_q ? ST_IDLE : ST_SQRT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					base_x_q   <= {in_cx[CX_W-1], in_cx} - XY_W'(in_w >> 1);
					y_q        <= {in_cy[CY_W-1], in_cy} - XY_W'(in_r);
					w_q        <= in_w;
					hw_q       <= in_w[SW_W-1:1];
					r_q        <= in_r;
					cap_q      <= (h_sat > PLAIN_LIMIT);
					row_q      <= '0;
					last_row_q <= h_sat - HEIGHT_W'(1);
					dy_q       <= '0 - {1'b0, in_r};
					// top row: dy = -r, so r*r - dy*dy = 0
					val_q      <= '0;
					rem_q      <= '0;
					res_q      <= '0;
					bit_q      <= BIT_TOP;
					cnt_q      <= '0;
				end
			end
			ST_SQRT: begin
				rem_q <= rem_nx;
				res_q <= res_nx;
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + CNT_W'(1);
				if (sqrt_last) begin
					ox_q    <= row_x;
					oy_q    <= y_q;
					ow_q    <= row_w;
					olast_q <= (row_q == last_row_q);
				end
			end
			ST_OUT: begin
				// advance to the next row once the span is taken
				if (out_fire && !olast_q) begin
					row_q <= row_q + HEIGHT_W'(1);
					y_q   <= y_q + XY_W'(1);
					dy_q  <= dy_q + (R_W + 1)'(1);
					val_q <= val_nx;
					rem_q <= val_nx;
					res_q <= '0;
					bit_q <= BIT_TOP;
					cnt_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, ow_q, oy_q, ox_q};
	assign m_axis_tlast = olast_q;

endmodule
`default_nettype wire

>>> rtl/core/stadium_span_rasterizer_checker.sv
`default_nettype none
module ssr_checker
	import ssr_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tlast
);

	// hold a span until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("span dropped or changed while stalled");

	// never take a shape while a span is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("request accepted during span output");

	// a shape's final span frees the input
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("input not ready after last span");

	// more rows follow a span without tlast
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
		else $error("input ready in the middle of a shape");

	// no span in the cycle after a request transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
		else $error("span appeared too early");

endmodule

bind stadium_span_rasterizer ssr_checker u_ssr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

>>> dv/tb_stadium_span_rasterizer.sv
module tb_stadium_span_rasterizer;
	import ssr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ROWS      = 64;
	// extra cycles to watch for stray spans once every expected span is back
	localparam int DRAIN_CYCLES  = 600;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_OFF_LEN  = 600;
	localparam int HOLD_OFF_AT   = 20;
	localparam int CALM_TAIL     = 20;
	localparam int RANDOM_SHAPES = 104;

	// one expected or observed row of a shape
	typedef struct packed {
		logic [XY_W-1:0]     span_x;
		logic [XY_W-1:0]     span_y;
		logic [SPAN_W_W-1:0] span_width;
		logic                last_span;
	} span_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// center_x[11:0], center_y[23:12], shape_width[31:24], shape_height[38:32], zero fill
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// span_x[12:0], span_y[25:13], span_width[34:26], zero fill
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	logic [IN_TDATA_W-1:0]  shape_queue[$];
	span_t                  expected_spans[$];
	int                     total_shapes;
	int                     shapes_sent;
	int                     mismatches;
	int                     shape_idle_left;
	int                     ready_idle_left;
	int                     hold_off_left;
	logic                   hold_off_done;
	int                     cycle_count = 0;

	stadium_span_rasterizer #(
		.MAX_HEIGHT(MAX_ROWS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Pack one shape request into the slave-side tdata layout.
	function automatic logic [IN_TDATA_W-1:0] pack_shape(input int cx, input int cy,
			input int w, input int h);
		logic [IN_TDATA_W-1:0] item;
		item = '0;
		item[CX_LSB +: CX_W]     = cx[CX_W-1:0];
		item[CY_LSB +: CY_W]     = cy[CY_W-1:0];
		item[SW_LSB +: SW_W]     = w[SW_W-1:0];
		item[SH_LSB +: HEIGHT_W] = h[HEIGHT_W-1:0];
		return item;
	endfunction

	// Work out every span of one accepted shape and append it to expected_spans.
	function automatic void rasterize_shape(input logic [IN_TDATA_W-1:0] item);
		logic signed [CX_W-1:0] cx_field;
		logic signed [CY_W-1:0] cy_field;
		int    cx, cy, w, h, half_w, r, dy, dx, sq, x, y, lw;
		span_t row;
		cx_field = item[CX_LSB +: CX_W];
		cy_field = item[CY_LSB +: CY_W];
		cx       = cx_field;
		cy       = cy_field;
		w        = item[SW_LSB +: SW_W];
		h        = item[SH_LSB +: HEIGHT_W];
		half_w   = w / 2;
		// clamp tall shapes to the largest supported height
		if (h > MAX_ROWS)
			h = MAX_ROWS;
		for (int i = 0; i < h; i++) begin
			y = cy - h / 2 + i;
			if (h <= PLAIN_LIMIT) begin
				x  = cx - half_w;
				lw = w;
			end else begin
				r  = h / 2;
				dy = y - cy;
				sq = r * r - dy * dy;
				// floor of the square root, zero for non-positive arguments
				dx = 0;
				if (sq > 0)
					while ((dx + 1) * (dx + 1) <= sq)
						dx++;
				x  = cx - half_w + r - dx;
				lw = (cx + half_w - r + dx) - x + 1;
			end
			// report negative widths as empty spans, keep x as computed
			if (lw < 0)
				lw = 0;
			row.span_x     = x[XY_W-1:0];
			row.span_y     = y[XY_W-1:0];
			row.span_width = lw[SPAN_W_W-1:0];
			row.last_span  = (i == h - 1);
			expected_spans.push_back(row);
		end
	endfunction

	// Shape driver: offer queued shapes, hold each until its transfer, idle in bursts.
	always @(posedge clk or negedge arst_n) begin : shape_driver
		logic taken;
		if (!arst_n) begin
			s_axis_tvalid   <= 1'b0;
			s_axis_tdata    <= '0;
			shape_idle_left <= 0;
			shapes_sent     <= 0;
		end else begin
			taken = s_axis_tvalid && s_axis_tready;
			if (taken) begin
				rasterize_shape(s_axis_tdata);
				shapes_sent <= shapes_sent + 1;
			end
			// hold the current shape until the block takes it
			if (!s_axis_tvalid || taken) begin
				if (shape_idle_left != 0) begin
					shape_idle_left <= shape_idle_left - 1;
					s_axis_tvalid   <= 1'b0;
				end else if (shape_queue.size() > CALM_TAIL &&
						$urandom_range(0, 5) == 0) begin
					shape_idle_left <= $urandom_range(0, 15);
					s_axis_tvalid   <= 1'b0;
				end else if (shape_queue.size() != 0) begin
					s_axis_tdata  <= shape_queue.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off once HOLD_OFF_AT shapes are through: the block fills up and
	// has to stall its input while the driver keeps offering.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off_left <= 0;
			hold_off_done <= 1'b0;
		end else if (!hold_off_done && shapes_sent >= HOLD_OFF_AT) begin
			hold_off_left <= HOLD_OFF_LEN;
			hold_off_done <= 1'b1;
		end else if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
		end
	end

	// Span monitor: check each transfer against the oldest expected span, drive tready.
	always @(posedge clk or negedge arst_n) begin : span_monitor
		span_t got;
		span_t want;
		if (!arst_n) begin
			m_axis_tready   <= 1'b0;
			ready_idle_left <= 0;
			mismatches      <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.span_x     = m_axis_tdata[SX_LSB +: XY_W];
				got.span_y     = m_axis_tdata[SY_LSB +: XY_W];
				got.span_width = m_axis_tdata[SPW_LSB +: SPAN_W_W];
				got.last_span  = m_axis_tlast;
				if (expected_spans.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected span: x=%0d y=%0d w=%0d last=%0b",
							$signed(got.span_x), $signed(got.span_y),
							got.span_width, got.last_span);
				end else begin
					want = expected_spans.pop_front();
					if (got !== want) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display({"span mismatch: expected x=%0d y=%0d w=%0d last=%0b,",
								" got x=%0d y=%0d w=%0d last=%0b"},
								$signed(want.span_x), $signed(want.span_y),
								want.span_width, want.last_span,
								$signed(got.span_x), $signed(got.span_y),
								got.span_width, got.last_span);
					end
				end
			end
			// drop tready during the hold-off and in random bursts; no new burst starts in the tail
			if (hold_off_left != 0) begin
				m_axis_tready <= 1'b0;
			end else if (ready_idle_left != 0) begin
				ready_idle_left <= ready_idle_left - 1;
				m_axis_tready   <= 1'b0;
			end else if (shapes_sent < total_shapes - CALM_TAIL &&
					$urandom_range(0, 7) == 0) begin
				ready_idle_left <= $urandom_range(0, 15);
				m_axis_tready   <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int h;
		arst_n = 1'b0;

		// directed shapes: field extremes, plain rectangles, first capped height,
		// zero height, saturated heights and zero width
		shape_queue.push_back(pack_shape(-2048, -2048, 255, 64));
		shape_queue.push_back(pack_shape(2047, 2047, 255, 64));
		shape_queue.push_back(pack_shape(2047, -2048, 1, 1));
		shape_queue.push_back(pack_shape(-2048, 2047, 1, 2));
		shape_queue.push_back(pack_shape(0, 0, 10, 3));
		shape_queue.push_back(pack_shape(5, -7, 11, 4));
		shape_queue.push_back(pack_shape(-3, 9, 20, 5));
		shape_queue.push_back(pack_shape(100, 100, 30, 0));
		shape_queue.push_back(pack_shape(-100, 50, 40, 65));
		shape_queue.push_back(pack_shape(1234, -1234, 200, 127));
		shape_queue.push_back(pack_shape(0, 0, 0, 1));
		shape_queue.push_back(pack_shape(0, 0, 0, 3));
		shape_queue.push_back(pack_shape(17, -17, 0, 10));
		shape_queue.push_back(pack_shape(-1, 1, 1, 64));
		shape_queue.push_back(pack_shape(2047, 2047, 254, 63));
		shape_queue.push_back(pack_shape(-2048, -2048, 128, 8));

		// random shapes: mostly capped heights, some plain, zero and oversized ones
		for (int i = 0; i < RANDOM_SHAPES; i++) begin
			case ($urandom_range(0, 9))
				0:       h = $urandom_range(0, 3);
				1:       h = $urandom_range(65, 127);
				2:       h = $urandom_range(56, 64);
				default: h = $urandom_range(4, 32);
			endcase
			shape_queue.push_back(pack_shape($urandom_range(0, 4095),
				$urandom_range(0, 4095), $urandom_range(0, 255), h));
		end
		total_shapes = shape_queue.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every shape to transfer and every span to come back
		while (shapes_sent < total_shapes || expected_spans.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_spans.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> stadium_span_rasterizer.f
rtl/core/ssr_pkg.sv
rtl/core/stadium_span_rasterizer.sv
rtl/core/stadium_span_rasterizer_checker.sv
dv/tb_stadium_span_rasterizer.sv
